### hdl/dfx_pkg.sv
// Package for the delimiter frame extractor: payload and entry types,
// configuration register map and the delimiter compare helpers.
// No dependencies.
package dfx_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int MAX_DELIM    = 7;
    localparam int CH_W         = 4;
    localparam int DELIM_W      = 8 * MAX_DELIM;
    localparam int APB_AW       = 6;
    localparam int APB_DW       = 64;

    typedef enum logic [0:0] {
        REQ_DATA  = 1'b0,
        REQ_CLOSE = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        REG_FRAME_ENABLE  = 3'd0,
        REG_HEADER_BYTES  = 3'd1,
        REG_HEADER_LEN    = 3'd2,
        REG_TRAILER_BYTES = 3'd3,
        REG_TRAILER_LEN   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic            req_type;
        logic [CH_W-1:0] channel;
        logic [7:0]      data_byte;
        logic            read_end;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic [7:0]      out_byte;
        logic            out_last;
    } t_out_item;

    typedef struct packed {
        logic               frame_enable;
        logic [DELIM_W-1:0] header_bytes;
        logic [2:0]         header_len;
        logic [DELIM_W-1:0] trailer_bytes;
        logic [2:0]         trailer_len;
    } t_cfg;

    // Per-channel state word. Only the newest seven bytes of history are
    // kept, which is all that matching and the delayed payload need.
    typedef struct packed {
        logic               in_frame;
        logic [DELIM_W-1:0] hist;
        logic [3:0]         cnt;
    } t_entry;

    typedef struct packed {
        logic      wr_en;
        t_entry    wr_data;
        logic      res_valid;
        t_out_item res;
    } t_upd;

    function automatic logic [2:0] eff_len(input logic [2:0] len);
        logic [2:0] r;
        r = len;
        if (len == 3'd0) begin
            r = 3'd1;
        end else if (32'(len) > MAX_DELIM) begin
            r = 3'(MAX_DELIM);
        end
        return r;
    endfunction

    // The newest len bytes of h (newest in bits 7:0) equal the first len
    // bytes of the delimiter, oldest history byte against delimiter byte 0.
    function automatic logic delim_match(input logic [DELIM_W-1:0] h,
                                         input logic [DELIM_W-1:0] d,
                                         input logic [2:0]         len);
        logic       m;
        logic [2:0] pos;
        m = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++) begin
            pos = len - 3'd1 - 3'(i);
            if ((3'(i) < len) && (h[8*pos +: 8] != d[8*i +: 8])) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

endpackage

### hdl/dfx_cfg_regs.sv
// Configuration register file behind an APB-style port.
// Depends on dfx_pkg for the register map and the t_cfg struct.
module dfx_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfx_pkg::APB_AW-1:0] paddr,
    input  logic [dfx_pkg::APB_DW-1:0] pwdata,
    output logic [dfx_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output dfx_pkg::t_cfg              o_cfg
);
    import dfx_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_enable  <= 1'b0;
            r_cfg.header_bytes  <= '0;
            r_cfg.header_len    <= 3'd1;
            r_cfg.trailer_bytes <= '0;
            r_cfg.trailer_len   <= 3'd1;
        end else if (wr) begin
            case (idx)
                REG_FRAME_ENABLE:  r_cfg.frame_enable  <= pwdata[0];
                REG_HEADER_BYTES:  r_cfg.header_bytes  <= pwdata[DELIM_W-1:0];
                REG_HEADER_LEN:    r_cfg.header_len    <= pwdata[2:0];
                REG_TRAILER_BYTES: r_cfg.trailer_bytes <= pwdata[DELIM_W-1:0];
                REG_TRAILER_LEN:   r_cfg.trailer_len   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_FRAME_ENABLE:  prdata = APB_DW'(r_cfg.frame_enable);
            REG_HEADER_BYTES:  prdata = APB_DW'(r_cfg.header_bytes);
            REG_HEADER_LEN:    prdata = APB_DW'(r_cfg.header_len);
            REG_TRAILER_BYTES: prdata = APB_DW'(r_cfg.trailer_bytes);
            REG_TRAILER_LEN:   prdata = APB_DW'(r_cfg.trailer_len);
            default:           prdata = '0;
        endcase
    end

endmodule

### hdl/dfx_state_ram.sv
// Per-channel state memory: one write port, one read port, registered read.
// Depends on dfx_pkg for the entry type and channel count.
module dfx_state_ram (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [dfx_pkg::CH_W-1:0] i_rd_addr,
    output dfx_pkg::t_entry          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [dfx_pkg::CH_W-1:0] i_wr_addr,
    input  dfx_pkg::t_entry          i_wr_data
);
    import dfx_pkg::*;

    t_entry r_mem [NUM_CHANNELS];
    t_entry r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hdl/dfx_update.sv
// Read-modify-write logic for one item: delimiter matching, history shift,
// counter update and the delayed payload byte. Depends on dfx_pkg.
module dfx_update (
    input  dfx_pkg::t_cfg     i_cfg,
    input  dfx_pkg::t_in_item i_item,
    input  dfx_pkg::t_entry   i_entry,
    output dfx_pkg::t_upd     o_upd
);
    import dfx_pkg::*;

    logic [DELIM_W+7:0] h;
    logic [3:0]         cnt;
    logic [2:0]         hl;
    logic [2:0]         tl;
    logic               in_range;
    logic               hdr_hit;
    logic               done;
    logic               has_payload;

    assign in_range = (32'(i_item.channel) < NUM_CHANNELS);
    assign h        = {i_entry.hist, i_item.data_byte};
    assign cnt      = (i_entry.cnt == 4'hF) ? 4'hF : i_entry.cnt + 4'd1;
    assign hl       = eff_len(i_cfg.header_len);
    assign tl       = eff_len(i_cfg.trailer_len);
    assign hdr_hit  = (cnt >= {1'b0, hl})
                   && delim_match(h[DELIM_W-1:0], i_cfg.header_bytes, hl);
    assign done     = (cnt >= {1'b0, tl})
                   && delim_match(h[DELIM_W-1:0], i_cfg.trailer_bytes, tl);
    assign has_payload = (cnt > {1'b0, tl});

    always_comb begin
        o_upd                  = '0;
        o_upd.res.out_channel  = i_item.channel;
        o_upd.wr_data.in_frame = i_entry.in_frame;
        o_upd.wr_data.hist     = h[DELIM_W-1:0];
        o_upd.wr_data.cnt      = cnt;
        if (!in_range) begin
            o_upd.wr_en = 1'b0;
        end else if (i_item.req_type == REQ_CLOSE) begin
            o_upd.wr_en   = 1'b1;
            o_upd.wr_data = '0;
        end else if (!i_cfg.frame_enable) begin
            // Pass-through leaves the channel state alone.
            o_upd.res_valid    = 1'b1;
            o_upd.res.out_byte = i_item.data_byte;
            o_upd.res.out_last = i_item.read_end;
        end else if (!i_entry.in_frame) begin
            o_upd.wr_en = 1'b1;
            if (hdr_hit) begin
                o_upd.wr_data.in_frame = 1'b1;
                o_upd.wr_data.cnt      = 4'd0;
            end
        end else begin
            o_upd.wr_en = 1'b1;
            if (done) begin
                o_upd.wr_data.in_frame = 1'b0;
                o_upd.wr_data.cnt      = 4'd0;
            end
            o_upd.res_valid    = has_payload;
            o_upd.res.out_byte = h[8*tl +: 8];
            o_upd.res.out_last = done;
        end
    end

endmodule

### hdl/delimiter_frame_extractor.sv
// Top level of the delimiter frame extractor: input stage, state memory with
// forwarding, update logic and output register. Depends on dfx_pkg,
// dfx_cfg_regs, dfx_state_ram and dfx_update.
//
// Usage. Bytes of up to sixteen interleaved channels arrive on the input
// channel (i_in_valid, o_in_stall, i_in_data); stripped payload bytes leave on
// the output channel (o_out_valid, i_out_stall, o_out_data). A transfer
// happens on a rising edge with valid high and stall low. A close request
// clears its channel's state and produces nothing.
// A result passes the update stage, then the output register. The block
// takes one transfer per cycle while the output is not stalled, set by the
// single read-modify-write of the state memory: the channel entry is read at
// transfer, modified and written back as its item leaves the update stage,
// the value just written being forwarded to a following same-channel item.
// When the receiver stalls, the output register holds its result and the
// item behind it waits in the update stage; o_in_stall rises only once both
// are occupied. Items that produce no result still wait behind a stalled
// output.
// Reset clears the configuration (framing off, delimiters zero, lengths one)
// and the per-channel valid flags, so every channel reads as cleared until
// it is first written; no clearing pass is needed.
// Configuration is written over the APB port while the block is idle.
module delimiter_frame_extractor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dfx_pkg::APB_AW-1:0] paddr,
    input  logic [dfx_pkg::APB_DW-1:0] pwdata,
    output logic [dfx_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dfx_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dfx_pkg::t_out_item         o_out_data
);
    import dfx_pkg::*;

    t_cfg      cfg;
    t_entry    rd_data;
    t_entry    cur_entry;
    t_upd      upd;

    // Update stage.
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_s1_fwd;
    t_entry    r_s1_fwd_data;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Set once a channel's entry has been written since reset.
    logic [NUM_CHANNELS-1:0] r_ent_valid;

    logic      out_free;
    logic      s1_fire;
    logic      in_acc;
    logic      wr_en;
    logic      fwd_hit;

    dfx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = s1_fire && upd.wr_en;

    // A write landing on the same edge as the read would be missed by the
    // memory, so its data is captured alongside the item instead.
    assign fwd_hit = wr_en && (r_s1_item.channel == i_in_data.channel);

    dfx_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_in_data.channel),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_item.channel),
        .i_wr_data (upd.wr_data)
    );

    always_comb begin
        if (r_s1_fwd) begin
            cur_entry = r_s1_fwd_data;
        end else if (r_ent_valid[r_s1_item.channel]) begin
            cur_entry = rd_data;
        end else begin
            cur_entry = '0;
        end
    end

    dfx_update u_upd (
        .i_cfg   (cfg),
        .i_item  (r_s1_item),
        .i_entry (cur_entry),
        .o_upd   (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ent_valid <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= s1_fire && upd.res_valid;
            end
            if (wr_en) begin
                r_ent_valid[r_s1_item.channel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item     <= i_in_data;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= upd.wr_data;
        end
        if (s1_fire) begin
            r_out <= upd.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The input is only held off while an item waits in the update stage.
    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty update stage");

    // A close always writes back a cleared entry.
    a_close_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_s1_item.req_type == REQ_CLOSE) |-> (upd.wr_data == '0))
        else $error("close did not clear the channel entry");

    // The last byte of a frame leaves the channel hunting again.
    a_last_ends_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && cfg.frame_enable && upd.res_valid && upd.res.out_last)
            |-> (wr_en && !upd.wr_data.in_frame))
        else $error("frame end did not clear in_frame");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the delimiter frame extractor: queued byte and
// close transfers on interleaved channels, an in-order predictor and a checker.
// Depends on dfx_pkg and delimiter_frame_extractor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfx_pkg::*;

    // The run is ended by force well beyond the slowest legal completion.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Cycles allowed after the last result before the registers are touched,
    // since transfers that produce nothing may still be working through.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Length of the single long receiver hold-off.
    localparam int unsigned HOLD_CYCLES   = 250;
    // Per-cycle idling probability of each side, in percent.
    localparam int unsigned IDLE_PCT      = 33;
    // Items of random stimulus per configuration phase.
    localparam int unsigned PHASE_ITEMS   = 160;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_AW-1:0]     paddr   = '0;
    logic [APB_DW-1:0]     pwdata  = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    delimiter_frame_extractor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the configuration registers and of the per-channel deframing
    // state. The shadow registers follow the APB writes; the channel state
    // advances with every accepted close or framed input transfer.
    t_cfg        shadow_cfg;
    logic        chan_in_frame [NUM_CHANNELS];
    logic [63:0] chan_history  [NUM_CHANNELS];
    logic [3:0]  chan_count    [NUM_CHANNELS];

    // Payload bytes that the block owes us, oldest first.
    t_out_item   payload_due[$];
    // Input transfers waiting to be offered to the block.
    t_in_item    byte_queue[$];
    // Per-channel staging used while interleaving frames of several channels.
    t_in_item    lanes [NUM_CHANNELS][$];

    int unsigned mismatches   = 0;
    int unsigned issued_count = 0;
    int unsigned taken_count  = 0;
    int unsigned cycle_count  = 0;
    logic        taken_last   = 1'b0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        calm;

    // A window of transfers in which neither side idles at all.
    assign calm = (taken_count >= 700) && (taken_count < 950);

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Effective delimiter length: zero behaves as one, and anything above the
    // widest delimiter is clipped to it.
    function automatic int unsigned span(input logic [2:0] len);
        if (len == 3'd0) begin
            return 1;
        end
        if (len > MAX_DELIM) begin
            return MAX_DELIM;
        end
        return len;
    endfunction

    // True when the newest n history bytes spell the first n delimiter
    // bytes, the oldest history byte against delimiter byte zero.
    function automatic logic tail_matches(input logic [63:0] h,
                                          input logic [DELIM_W-1:0] d,
                                          input int unsigned n);
        for (int i = 0; i < n; i++) begin
            if (h[8*(n-1-i) +: 8] != d[8*i +: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the shadow channel state by one accepted transfer and report
    // whether a payload byte comes out of it, and which.
    function automatic logic deframe_step(input t_in_item it, output t_out_item res);
        int unsigned ch;
        int unsigned k;
        logic [63:0] h;
        logic [3:0]  n;
        logic        has_payload;
        logic        closing;
        ch  = it.channel;
        res = '0;
        if (it.req_type == REQ_CLOSE) begin
            chan_in_frame[ch] = 1'b0;
            chan_history[ch]  = '0;
            chan_count[ch]    = '0;
            return 1'b0;
        end
        // With framing off the byte passes straight through and the channel
        // state is left exactly as it was.
        if (!shadow_cfg.frame_enable) begin
            res.out_channel = it.channel;
            res.out_byte    = it.data_byte;
            res.out_last    = it.read_end;
            return 1'b1;
        end
        h = {chan_history[ch][55:0], it.data_byte};
        chan_history[ch] = h;
        n = (chan_count[ch] == 4'd15) ? 4'd15 : chan_count[ch] + 4'd1;
        chan_count[ch] = n;
        // Hunting: only the header is looked for, and only among bytes seen
        // since the last mark. Everything here is dropped.
        if (!chan_in_frame[ch]) begin
            k = span(shadow_cfg.header_len);
            if (n >= k && tail_matches(h, shadow_cfg.header_bytes, k)) begin
                chan_in_frame[ch] = 1'b1;
                chan_count[ch]    = '0;
            end
            return 1'b0;
        end
        // Inside a frame: payload lags by one trailer length, so the byte
        // leaving is the one just older than a possible trailer.
        k = span(shadow_cfg.trailer_len);
        has_payload = n > k;
        closing     = (n >= k) && tail_matches(h, shadow_cfg.trailer_bytes, k);
        if (closing) begin
            chan_in_frame[ch] = 1'b0;
            chan_count[ch]    = '0;
        end
        if (!has_payload) begin
            return 1'b0;
        end
        res.out_channel = it.channel;
        res.out_byte    = h[8*k +: 8];
        res.out_last    = closing;
        return 1'b1;
    endfunction

    // Checker and predictor. Results are compared before the input transfer
    // of the same edge is predicted, so a result can never be matched with
    // an item accepted in the same cycle.
    always @(posedge i_clk) begin : check_and_predict
        t_out_item want;
        t_out_item fresh;
        if (o_out_valid && !i_out_stall) begin
            if (payload_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result ch %0d byte %02h last %0b",
                                        o_out_data.out_channel, o_out_data.out_byte,
                                        o_out_data.out_last));
            end else begin
                want = payload_due.pop_front();
                if (o_out_data.out_channel !== want.out_channel) begin
                    flag_mismatch($sformatf("out_channel %0d, predicted %0d",
                                            o_out_data.out_channel, want.out_channel));
                end
                if (o_out_data.out_byte !== want.out_byte) begin
                    flag_mismatch($sformatf("out_byte %02h, predicted %02h on ch %0d",
                                            o_out_data.out_byte, want.out_byte,
                                            want.out_channel));
                end
                if (o_out_data.out_last !== want.out_last) begin
                    flag_mismatch($sformatf("out_last %0b, predicted %0b on ch %0d",
                                            o_out_data.out_last, want.out_last,
                                            want.out_channel));
                end
            end
        end
        if (i_in_valid && !o_in_stall) begin
            taken_count <= taken_count + 1;
            if (deframe_step(i_in_data, fresh)) begin
                payload_due = {payload_due, fresh};
            end
        end
        taken_last <= i_in_valid && !o_in_stall;
    end

    // Sender. A new transfer is only presented once the previous one has
    // gone, so a stalled payload never changes and valid ignores the stall.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || taken_last)) begin
            if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_data  <= byte_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Random stalls, none in the calm window, and one long
    // hold-off taken mid-phase so that the block fills and stalls its input
    // while the sender keeps offering transfers.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && taken_count >= 400 && byte_queue.size() > 60) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic offer(input t_in_item it);
        byte_queue = {byte_queue, it};
        issued_count++;
    endtask

    function automatic t_in_item data_item(input int unsigned ch, input logic [7:0] b,
                                           input logic re);
        t_in_item it;
        it.req_type  = REQ_DATA;
        it.channel   = CH_W'(ch);
        it.data_byte = b;
        it.read_end  = re;
        return it;
    endfunction

    // The byte and read_end of a close are don't-cares, so they are random.
    function automatic t_in_item close_item(input int unsigned ch);
        t_in_item it;
        it.req_type  = REQ_CLOSE;
        it.channel   = CH_W'(ch);
        it.data_byte = 8'($urandom);
        it.read_end  = 1'($urandom);
        return it;
    endfunction

    function automatic logic [DELIM_W-1:0] rand_delim();
        return DELIM_W'({$urandom, $urandom});
    endfunction

    task automatic push_delim(input int unsigned ch, input logic [DELIM_W-1:0] d,
                              input int unsigned n);
        for (int i = 0; i < n; i++) begin
            lanes[ch] = {lanes[ch], data_item(ch, d[8*i +: 8], 1'($urandom))};
        end
    endtask

    // One stretch of traffic for a channel under the current delimiters.
    // Most are well-formed frames; the rest are loose bytes, stray trailers,
    // empty frames and frames cut short by a close.
    task automatic build_frame(input int unsigned ch);
        int unsigned hl;
        int unsigned tl;
        int unsigned shape;
        int unsigned body;
        hl    = span(shadow_cfg.header_len);
        tl    = span(shadow_cfg.trailer_len);
        shape = $urandom_range(99);
        body  = $urandom_range(12, 1);
        if (shape < 8) begin
            // Loose bytes while hunting, now and then a close among them.
            for (int i = 0; i < body; i++) begin
                if ($urandom_range(7) == 0) begin
                    lanes[ch] = {lanes[ch], close_item(ch)};
                end else begin
                    lanes[ch] = {lanes[ch], data_item(ch, 8'($urandom), 1'($urandom))};
                end
            end
            return;
        end
        if (shape < 14) begin
            push_delim(ch, shadow_cfg.trailer_bytes, tl);
        end
        push_delim(ch, shadow_cfg.header_bytes, hl);
        if (shape >= 14 && shape < 20) begin
            body = 0;
        end
        for (int i = 0; i < body; i++) begin
            if ($urandom_range(19) == 0) begin
                // A header inside the payload is ordinary data.
                push_delim(ch, shadow_cfg.header_bytes, hl);
            end else if ($urandom_range(19) == 0 && tl > 1) begin
                // A trailer that stops one byte short must not end the frame.
                push_delim(ch, shadow_cfg.trailer_bytes, tl - 1);
            end else begin
                lanes[ch] = {lanes[ch], data_item(ch, 8'($urandom), 1'($urandom))};
            end
        end
        if (shape >= 20 && shape < 26) begin
            lanes[ch] = {lanes[ch], close_item(ch)};
        end else begin
            push_delim(ch, shadow_cfg.trailer_bytes, tl);
        end
    endtask

    // Frames for a few channels, interleaved in short bursts per channel.
    task automatic run_framed_phase(input int unsigned budget);
        int unsigned active[$];
        int unsigned ways;
        int unsigned made;
        int unsigned left;
        int unsigned ch;
        int unsigned burst;
        int unsigned was;
        ways = $urandom_range(4, 1);
        for (int i = 0; i < ways; i++) begin
            active = {active, $urandom_range(NUM_CHANNELS - 1)};
        end
        made = 0;
        while (made < budget) begin
            ch  = active[$urandom_range(active.size() - 1)];
            was = lanes[ch].size();
            build_frame(ch);
            made += lanes[ch].size() - was;
        end
        left = made;
        while (left != 0) begin
            ch    = active[$urandom_range(active.size() - 1)];
            burst = $urandom_range(4, 1);
            while (burst != 0 && lanes[ch].size() != 0) begin
                offer(lanes[ch].pop_front());
                burst--;
                left--;
            end
        end
    endtask

    // Free-running traffic over every channel, with the odd close.
    task automatic run_plain_phase(input int unsigned budget);
        for (int i = 0; i < budget; i++) begin
            if ($urandom_range(15) == 0) begin
                offer(close_item($urandom_range(NUM_CHANNELS - 1)));
            end else begin
                offer(data_item($urandom_range(NUM_CHANNELS - 1), 8'($urandom),
                                1'($urandom)));
            end
        end
    endtask

    // Waits until every offered transfer has been taken and every predicted
    // result delivered, then lets the pipeline drain. Ends on a falling edge.
    task automatic wait_idle();
        while (taken_count != issued_count || payload_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the rising edge inside the access cycle, pready being always high.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(8 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_ENABLE:  shadow_cfg.frame_enable  = value[0];
            REG_HEADER_BYTES:  shadow_cfg.header_bytes  = value[DELIM_W-1:0];
            REG_HEADER_LEN:    shadow_cfg.header_len    = value[2:0];
            REG_TRAILER_BYTES: shadow_cfg.trailer_bytes = value[DELIM_W-1:0];
            REG_TRAILER_LEN:   shadow_cfg.trailer_len   = value[2:0];
            default: ;
        endcase
    endtask

    // Writes the whole register set, then steps to a rising edge so that the
    // new stimulus is queued away from the sender's falling-edge activity.
    task automatic apply_setting(input logic fe, input logic [DELIM_W-1:0] hb,
                                 input logic [2:0] hl, input logic [DELIM_W-1:0] tb,
                                 input logic [2:0] tl);
        write_reg(REG_FRAME_ENABLE, APB_DW'(fe));
        write_reg(REG_HEADER_BYTES, APB_DW'(hb));
        write_reg(REG_HEADER_LEN, APB_DW'(hl));
        write_reg(REG_TRAILER_BYTES, APB_DW'(tb));
        write_reg(REG_TRAILER_LEN, APB_DW'(tl));
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [DELIM_W-1:0] twin;
        shadow_cfg.frame_enable  = 1'b0;
        shadow_cfg.header_bytes  = '0;
        shadow_cfg.header_len    = 3'd1;
        shadow_cfg.trailer_bytes = '0;
        shadow_cfg.trailer_len   = 3'd1;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            chan_in_frame[ch] = 1'b0;
            chan_history[ch]  = '0;
            chan_count[ch]    = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset configuration: plain pass-through at the field
        // extremes, with a close that must produce nothing.
        offer(data_item(0, 8'h00, 1'b0));
        offer(data_item(15, 8'hFF, 1'b1));
        offer(data_item(5, 8'hA5, 1'b1));
        offer(close_item(3));
        offer(data_item(10, 8'h5A, 1'b0));
        wait_idle();

        // Directed, one-byte header and trailer: a stray trailer and a loose
        // byte while hunting, a header kept as payload, a normal ending, an
        // empty frame, and a close in the middle of a frame.
        apply_setting(1'b1, DELIM_W'(8'h7E), 3'd1, DELIM_W'(8'h7F), 3'd1);
        offer(data_item(1, 8'h7F, 1'b0));
        offer(data_item(1, 8'h11, 1'b1));
        offer(data_item(1, 8'h7E, 1'b0));
        offer(data_item(1, 8'h7E, 1'b1));
        offer(data_item(1, 8'h22, 1'b0));
        offer(data_item(1, 8'h7F, 1'b0));
        offer(data_item(1, 8'h7E, 1'b0));
        offer(data_item(1, 8'h7F, 1'b1));
        offer(data_item(2, 8'h7E, 1'b0));
        offer(data_item(2, 8'h33, 1'b0));
        offer(close_item(2));
        offer(data_item(2, 8'h44, 1'b0));
        offer(data_item(2, 8'h7F, 1'b0));
        wait_idle();

        // Random phases. Channel state is carried across each change,
        // including the switches of framing on and off.
        apply_setting(1'b1, rand_delim(), 3'd3, rand_delim(), 3'd2);
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        // Widest delimiters, all ones against all zeros.
        apply_setting(1'b1, {DELIM_W{1'b1}}, 3'd7, '0, 3'd7);
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        apply_setting(1'b0, rand_delim(), 3'($urandom), rand_delim(), 3'($urandom));
        run_plain_phase(PHASE_ITEMS);
        wait_idle();

        // Zero lengths behave as one byte.
        apply_setting(1'b1, rand_delim(), 3'd0, rand_delim(), 3'd0);
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        // Header and trailer identical.
        twin = rand_delim();
        apply_setting(1'b1, twin, 3'd4, twin, 3'd4);
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        // A self-overlapping trailer of one repeated byte.
        apply_setting(1'b1, rand_delim(), 3'd1, {7{8'hAA}}, 3'd3);
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        apply_setting(1'b1, rand_delim(), 3'($urandom_range(7, 1)), rand_delim(),
                      3'($urandom_range(7, 1)));
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        apply_setting(1'b1, rand_delim(), 3'($urandom), rand_delim(), 3'($urandom));
        run_framed_phase(PHASE_ITEMS);
        wait_idle();

        apply_setting(1'b0, rand_delim(), 3'($urandom), rand_delim(), 3'($urandom));
        run_plain_phase(PHASE_ITEMS);
        wait_idle();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
